FILE: design/lkc_pkg.sv
// Shared types and constants for the LRU keyed slot cache.
package lkc_pkg;

  localparam int ENTRIES_DEF = 8;
  localparam int ENTRIES_MAX = 64;
  localparam int KEY_W       = 8;
  localparam int SLOT_W      = 3;
  localparam int OUTCOME_W   = 2;
  // Slot index and rank are sized for the largest table.
  localparam int IDX_W       = $clog2(ENTRIES_MAX);
  localparam int RANK_W      = IDX_W;
  localparam int CNT_W       = $clog2(ENTRIES_MAX + 1);

  typedef enum logic [OUTCOME_W-1:0] {
    OUT_HIT     = 2'd0,
    OUT_FILL    = 2'd1,
    OUT_REPLACE = 2'd2
  } outcome_t;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_SCAN = 3'b010,
    S_DONE = 3'b100
  } state_t;

  // Search token passed from cell to cell.
  typedef struct packed {
    logic              go;
    logic              hit;
    logic [IDX_W-1:0]  sel;
    logic [RANK_W-1:0] rank;
    logic [IDX_W-1:0]  vict;
  } tok_t;

  // Update broadcast to every cell.
  typedef struct packed {
    logic              en;
    logic              ins;
    logic [IDX_W-1:0]  sel;
    logic [RANK_W-1:0] rank;
  } upd_t;

endpackage

FILE: design/lkc_cell.sv
// One slot of the cache: key, recency rank, search token stage.
module lkc_cell import lkc_pkg::*; #(
  parameter int ENTRIES = ENTRIES_DEF,
  parameter int IDX     = 0
) (
  input  logic              clk,
  input  logic              rst,
  input  logic [KEY_W-1:0]  key,
  input  logic [CNT_W-1:0]  in_use,
  input  tok_t              tok_in,
  output tok_t              tok_out,
  input  upd_t              upd
);

  logic [KEY_W-1:0]  slot_key;
  logic [RANK_W-1:0] rank;
  logic [RANK_W-1:0] rank_next;
  tok_t              tok_next;
  logic              occ;
  logic              mine;

  assign occ  = CNT_W'(IDX) < in_use;
  assign mine = upd.sel == IDX_W'(IDX);

  always_comb begin
    tok_next = tok_in;
    if (tok_in.go) begin
      if (occ && !tok_in.hit && slot_key == key) begin
        tok_next.hit  = 1'b1;
        tok_next.sel  = IDX_W'(IDX);
        tok_next.rank = rank;
      end
      // when full, ranks are distinct so the oldest is unique
      if (occ && rank == RANK_W'(ENTRIES - 1)) begin
        tok_next.vict = IDX_W'(IDX);
      end
    end
  end

  always_comb begin
    rank_next = rank;
    if (upd.en) begin
      if (mine) begin
        rank_next = '0;
      end else if (occ && (upd.ins || rank < upd.rank)) begin
        rank_next = rank + RANK_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rank    <= '0;
      tok_out <= '0;
    end else begin
      rank    <= rank_next;
      tok_out <= tok_next;
    end
  end

  always_ff @(posedge clk) begin
    if (upd.en && upd.ins && mine) begin
      slot_key <= key;
    end
  end

endmodule

FILE: design/lru_keyed_table_slot_cache.sv
// Fully associative slot cache with least-recently-used replacement.
//
// Input channel: key with in_valid / in_stall. Output channel: slot and
// outcome with out_valid / out_stall. A transfer happens on a clock edge
// with valid high and stall low. Every key yields exactly one result.
// A search token walks the row of slot cells, one cell per cycle, picking
// up a hit and the least recently used slot; the ranks and keys are then
// updated in all cells at once in the cycle the result is registered.
// Keys do not overlap: a new key is taken only after the result for the
// previous key has been loaded into the output register. A finished
// result sits in the output register, so the next key is accepted while
// it waits; the following result is held back until the output register
// is free. Reset empties the table (no slot in use) and clears both
// channels.
module lru_keyed_table_slot_cache import lkc_pkg::*; #(
  parameter int ENTRIES = ENTRIES_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [KEY_W-1:0]     key,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [SLOT_W-1:0]    slot,
  output logic [OUTCOME_W-1:0] outcome
);

  state_t             state;
  logic               start;
  logic [CNT_W-1:0]   in_use;
  logic [KEY_W-1:0]   key_q;
  tok_t               res;
  tok_t               chain [ENTRIES:0];
  upd_t               upd;
  logic [IDX_W-1:0]   dec_sel;
  outcome_t           dec_out;
  outcome_t           outcome_q;
  logic [SLOT_W-1:0]  slot_q;
  logic               out_free;

  assign chain[0] = '{go: start, hit: 1'b0, sel: '0, rank: '0, vict: '0};

  for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
    lkc_cell #(
      .ENTRIES (ENTRIES),
      .IDX     (i)
    ) u_cell (
      .clk     (clk),
      .rst     (rst),
      .key     (key_q),
      .in_use  (in_use),
      .tok_in  (chain[i]),
      .tok_out (chain[i+1]),
      .upd     (upd)
    );
  end

  always_comb begin
    dec_sel = res.sel;
    dec_out = OUT_HIT;
    priority if (res.hit) begin
      dec_sel = res.sel;
      dec_out = OUT_HIT;
    end else if (in_use < CNT_W'(ENTRIES)) begin
      dec_sel = in_use[IDX_W-1:0];
      dec_out = OUT_FILL;
    end else begin
      dec_sel = res.vict;
      dec_out = OUT_REPLACE;
    end
  end

  assign out_free = !out_valid || !out_stall;
  assign upd.en   = (state == S_DONE) && out_free;
  assign upd.ins  = !res.hit;
  assign upd.sel  = dec_sel;
  assign upd.rank = res.rank;

  assign in_stall = state != S_IDLE;
  assign slot     = slot_q;
  assign outcome  = outcome_q;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      start     <= 1'b0;
      in_use    <= '0;
      out_valid <= 1'b0;
    end else begin
      start     <= (state == S_IDLE) && in_valid;
      // load a new result, else hold a stalled one, else drop after transfer
      out_valid <= upd.en || (out_valid && out_stall);
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            state <= S_SCAN;
          end
        end
        S_SCAN: begin
          if (chain[ENTRIES].go) begin
            state <= S_DONE;
          end
        end
        S_DONE: begin
          if (out_free) begin
            state <= S_IDLE;
            if (dec_out == OUT_FILL) begin
              in_use <= in_use + CNT_W'(1);
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_IDLE && in_valid) begin
      key_q <= key;
    end
    if (state == S_SCAN && chain[ENTRIES].go) begin
      res <= chain[ENTRIES];
    end
    if (upd.en) begin
      slot_q    <= dec_sel[SLOT_W-1:0];
      outcome_q <= dec_out;
    end
  end

  a_in_use_bound: assert property (@(posedge clk) disable iff (rst)
    in_use <= CNT_W'(ENTRIES))
    else $error("slot count above table size");

  a_token_in_scan: assert property (@(posedge clk) disable iff (rst)
    chain[ENTRIES].go |-> state == S_SCAN)
    else $error("search token finished outside of a scan");

  a_fill_counts: assert property (@(posedge clk) disable iff (rst)
    upd.en && dec_out == OUT_FILL |=> in_use == $past(in_use) + CNT_W'(1))
    else $error("fill did not advance the slot count");

endmodule

FILE: sim/lru_keyed_table_slot_cache_check.sv
// Checker for the LRU slot cache: tracks the table and compares every result transfer.
module lru_keyed_table_slot_cache_check import lkc_pkg::*; #(
  parameter int ENTRIES = ENTRIES_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  input  logic                 in_stall,
  input  logic [KEY_W-1:0]     key,
  input  logic                 out_valid,
  input  logic                 out_stall,
  input  logic [SLOT_W-1:0]    slot,
  input  logic [OUTCOME_W-1:0] outcome,
  output int                   errors,
  output int                   waiting
);

  typedef struct packed {
    logic [SLOT_W-1:0] slot;
    outcome_t          outcome;
  } slot_answer_t;

  logic [KEY_W-1:0]  tag [ENTRIES];
  logic [RANK_W-1:0] age [ENTRIES];
  int                used = 0;
  int                err_cnt = 0;
  slot_answer_t      slot_answers [$];

  // Slots 0..used-1 are occupied; age 0 is the most recently used.
  function automatic slot_answer_t lookup_slot(input logic [KEY_W-1:0] k);
    slot_answer_t      a;
    int                pick;
    logic [RANK_W-1:0] ref_age;
    logic              found;
    found = 1'b0;
    pick  = 0;
    for (int i = 0; i < used; i++) begin
      if (!found && tag[i] == k) begin
        found = 1'b1;
        pick  = i;
      end
    end
    if (found) begin
      ref_age = age[pick];
      for (int i = 0; i < used; i++) begin
        if (age[i] < ref_age) age[i] = age[i] + 1'b1;
      end
      a.outcome = OUT_HIT;
    end else if (used < ENTRIES) begin
      for (int i = 0; i < used; i++) age[i] = age[i] + 1'b1;
      pick = used;
      used++;
      a.outcome = OUT_FILL;
    end else begin
      // victim is the oldest occupied slot; ages are distinct
      ref_age = '0;
      for (int i = 0; i < used; i++) begin
        if (age[i] > ref_age) begin
          ref_age = age[i];
          pick    = i;
        end
      end
      for (int i = 0; i < used; i++) begin
        if (i != pick) age[i] = age[i] + 1'b1;
      end
      a.outcome = OUT_REPLACE;
    end
    tag[pick] = k;
    age[pick] = '0;
    a.slot    = pick[SLOT_W-1:0];
    return a;
  endfunction

  always @(posedge clk) begin : watch
    slot_answer_t want;
    if (rst) begin
      used = 0;
      for (int i = 0; i < ENTRIES; i++) age[i] = '0;
      slot_answers.delete();
    end else begin
      // compare before pushing: a result never belongs to a key taken this edge
      if (out_valid && !out_stall) begin
        if (slot_answers.size() == 0) begin
          $error("result transfer with no lookup pending: slot %0d outcome %0d", slot, outcome);
          err_cnt++;
        end else begin
          want = slot_answers.pop_front();
          if (slot !== want.slot) begin
            $error("slot mismatch: expected %0d, actual %0d", want.slot, slot);
            err_cnt++;
          end
          if (outcome !== want.outcome) begin
            $error("outcome mismatch: expected %0d, actual %0d", want.outcome, outcome);
            err_cnt++;
          end
        end
      end
      if (in_valid && !in_stall) slot_answers.push_back(lookup_slot(key));
    end
    errors  <= err_cnt;
    waiting <= slot_answers.size();
  end

endmodule

FILE: sim/lru_keyed_table_slot_cache_test.sv
// Testbench top for the LRU slot cache: key stimulus, output stalls and the verdict.
module lru_keyed_table_slot_cache_test;
  import lkc_pkg::*;

  localparam int ITEMS      = 1900;
  localparam int QUIET_TAIL = 300;
  localparam int LIMIT      = 500000;
  localparam int DRAIN      = ENTRIES_DEF + 8;
  localparam int POOL_MAX   = 40;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  logic [KEY_W-1:0]     key = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic [SLOT_W-1:0]    slot;
  logic [OUTCOME_W-1:0] outcome;

  logic quiet = 1'b0;
  logic hold_off = 1'b0;
  int   items_sent = 0;
  int   gap_pct = 0;
  int   burst_left = 0;
  int   cycles = 0;
  int   errors;
  int   waiting;

  logic [KEY_W-1:0] pool [POOL_MAX];

  // fill, hit on MRU and LRU, replace when full, all-zero and all-one keys
  logic [KEY_W-1:0] warmup_keys [24] = '{
    8'd0, 8'd255, 8'd0, 8'd1, 8'd2, 8'd4, 8'd8, 8'd16,
    8'd32, 8'd128, 8'd0, 8'd0, 8'd1, 8'd2, 8'd170, 8'd85,
    8'd127, 8'd1, 8'd4, 8'd8, 8'd16, 8'd32, 8'd64, 8'd255
  };

  lru_keyed_table_slot_cache dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .key       (key),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .slot      (slot),
    .outcome   (outcome)
  );

  lru_keyed_table_slot_cache_check lookup_check (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .key       (key),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .slot      (slot),
    .outcome   (outcome),
    .errors    (errors),
    .waiting   (waiting)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Offer one key and hold it until the transfer; maybe idle afterwards.
  task automatic send_key(input logic [KEY_W-1:0] k);
    in_valid <= 1'b1;
    key      <= k;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    items_sent++;
    if (items_sent >= ITEMS - QUIET_TAIL) quiet <= 1'b1;
    if (!quiet && $urandom_range(1, 100) <= gap_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
    end
  endtask

  initial begin
    logic [KEY_W-1:0] k;
    int               pool_n;
    int               seg_len;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    gap_pct = 25;
    foreach (warmup_keys[i]) send_key(warmup_keys[i]);

    // Segments draw from a small key pool so hits, fills and evictions mix.
    while (items_sent < ITEMS) begin
      case ($urandom_range(0, 3))
        0:       pool_n = $urandom_range(1, 4);
        1:       pool_n = $urandom_range(5, 8);
        2:       pool_n = $urandom_range(9, 16);
        default: pool_n = $urandom_range(17, POOL_MAX);
      endcase
      for (int i = 0; i < pool_n; i++) pool[i] = KEY_W'($urandom_range(0, 255));
      seg_len = $urandom_range(20, 80);
      gap_pct = ($urandom_range(0, 2) == 0) ? 0 : 25;
      for (int j = 0; j < seg_len && items_sent < ITEMS; j++) begin
        if ($urandom_range(0, 9) == 0) k = KEY_W'($urandom_range(0, 255));
        else k = pool[$urandom_range(0, pool_n - 1)];
        send_key(k);
      end
    end
    in_valid <= 1'b0;

    @(posedge clk);
    while (waiting != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);
    if (errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  // Long receiver hold-off so the block backs up and stalls its input.
  initial begin
    repeat (3000) @(posedge clk);
    hold_off <= 1'b1;
    repeat (400) @(posedge clk);
    hold_off <= 1'b0;
  end

  // Receiver: stall bursts between free-running stretches.
  always @(posedge clk) begin
    if (rst || quiet) begin
      out_stall  <= 1'b0;
      burst_left <= 0;
    end else if (hold_off) begin
      out_stall <= 1'b1;
    end else if (burst_left != 0) begin
      burst_left <= burst_left - 1;
    end else if ($urandom_range(0, 2) == 0) begin
      out_stall  <= 1'b1;
      burst_left <= $urandom_range(0, 9);
    end else begin
      out_stall  <= 1'b0;
      burst_left <= $urandom_range(0, 39);
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

endmodule
